[rtl/core/tws_pkg.sv]
// tws_pkg: shared types, codes and constants of the time window power scheduler
// no dependencies; imported by time_window_power_scheduler and tws_eval
package tws_pkg;

  localparam int MaxEntriesDef = 16;
  localparam int StampW = 40;
  localparam int TodW = 17;
  localparam int DayW = 3;
  localparam int CntW = 5;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] MODE_STAMP = 2'd0;
  localparam logic [1:0] MODE_DAILY = 2'd1;
  localparam logic [1:0] MODE_WEEKLY = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COUNT = 2'd2;

  localparam logic [CntW-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic              opcode;
    logic [3:0]        entry_index;
    logic [StampW-1:0] entry_start_stamp;
    logic [StampW-1:0] entry_end_stamp;
    logic [TodW-1:0]   entry_start_tod;
    logic [TodW-1:0]   entry_end_tod;
    logic [DayW-1:0]   entry_weekday;
    logic              entry_active_init;
    logic [StampW-1:0] now_stamp;
    logic [TodW-1:0]   now_tod;
    logic [DayW-1:0]   now_weekday;
  } in_item_t;

  typedef struct packed {
    logic            power_on;
    logic [CntW-1:0] change_count;
  } out_item_t;

  // one schedule entry as stored in the table memory
  typedef struct packed {
    logic [StampW-1:0] start_stamp;
    logic [StampW-1:0] end_stamp;
    logic [TodW-1:0]   start_tod;
    logic [TodW-1:0]   end_tod;
    logic [DayW-1:0]   weekday;
    logic              active;
  } entry_t;

  // current time of a tick
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [TodW-1:0]   tod;
    logic [DayW-1:0]   weekday;
  } now_t;

  typedef struct packed {
    logic sw_on;
    logic sw_off;
  } decision_t;

endpackage

[rtl/core/time_window_power_scheduler.sv]
// time_window_power_scheduler: top level, control sequencer and table walk
// depends on tws_pkg, tws_ram, tws_eval
//
// A load item writes one schedule entry into the table memory when its index
// lies within the table and returns the current power state with a change
// count of zero. An enabled tick in a mode other than unused walks entries 0 ..
// min(entry_count, MAX_ENTRIES)-1 in order: one memory read is issued per cycle,
// and the entry read in the previous cycle is evaluated and, when it switches
// power, written back with its new active flag. The walk is paced by the single
// read port of the table memory; after the last entry is evaluated it closes
// and moves to the push state, which fills the result register once it is free
// and returns to idle; a load or a tick that walks nothing goes straight to the
// push state. One item is in work at a time; the next item is taken while a
// finished result still waits in the output register. Active flags read as zero
// after reset through one valid bit per entry; no clearing pass is needed. The
// window fields of a slot that was never loaded are undefined.
module time_window_power_scheduler #(
  parameter int MAX_ENTRIES = tws_pkg::MaxEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tws_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tws_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tws_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tws_pkg::CfgDataW-1:0]    cfg_data_i
);
  import tws_pkg::*;

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EntW = $bits(entry_t);

  // configuration registers
  logic [1:0]      mode_q;
  logic            enable_q;
  logic [CntW-1:0] count_q;

  // sequencer and walk state
  state_e          state_q, state_d;
  logic [CntW-1:0] walk_q;     // next entry to read
  logic [CntW-1:0] lim_q;      // entries to walk on this tick
  logic            rd_valid_q; // read data of entry rd_idx_q arrives this cycle
  logic [IdxW-1:0] rd_idx_q;
  logic            power_q;
  logic [CntW-1:0] chg_q;
  now_t            now_q;
  logic [MAX_ENTRIES-1:0] valid_q;

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  // memory side
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [EntW-1:0] ram_rdata;
  entry_t          ent_rd;

  decision_t       dec;
  logic            accept_in;
  logic            is_load;
  logic            slot_ok;
  logic            start_walk;
  logic            issue;
  logic            walk_done;
  logic            out_free;
  logic            do_switch;
  logic [CntW-1:0] lim_new;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_STAMP;
      enable_q <= 1'b0;
      count_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[1:0];
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_COUNT:  count_q  <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // handshake and walk control
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept_in  = in_valid_i && in_ready_o;
  assign is_load    = (in_data_i.opcode == OP_LOAD);
  assign slot_ok    = (int'(in_data_i.entry_index) < MAX_ENTRIES);
  // counts above the table depth walk the whole table
  assign lim_new    = (int'(count_q) > MAX_ENTRIES) ? CntW'(MAX_ENTRIES) : count_q;
  assign start_walk = !is_load && enable_q && (mode_q != MODE_UNUSED) && (lim_new != '0);
  assign issue      = (state_q == ST_WALK) && (walk_q < lim_q);
  assign walk_done  = (state_q == ST_WALK) && (walk_q == lim_q) && !rd_valid_q;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          state_d = start_walk ? ST_WALK : ST_PUSH;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // entry under evaluation; a never-written slot reads as inactive
  always_comb begin
    ent_rd        = entry_t'(ram_rdata);
    ent_rd.active = ram_rdata[0] & valid_q[rd_idx_q];
  end

  tws_eval u_eval (
    .mode_i  (mode_q),
    .now_i   (now_q),
    .entry_i (ent_rd),
    .power_i (power_q),
    .dec_o   (dec)
  );

  assign do_switch = rd_valid_q && (dec.sw_on || dec.sw_off);

  // loads write from the idle state, walk write-back only while walking
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx_q;
    ram_wdata = ent_rd;
    if (accept_in && is_load && slot_ok) begin
      ram_we                = 1'b1;
      ram_waddr             = IdxW'(in_data_i.entry_index);
      ram_wdata.start_stamp = in_data_i.entry_start_stamp;
      ram_wdata.end_stamp   = in_data_i.entry_end_stamp;
      ram_wdata.start_tod   = in_data_i.entry_start_tod;
      ram_wdata.end_tod     = in_data_i.entry_end_tod;
      ram_wdata.weekday     = in_data_i.entry_weekday;
      ram_wdata.active      = in_data_i.entry_active_init;
    end else if (do_switch) begin
      ram_we           = 1'b1;
      ram_wdata.active = dec.sw_on;
    end
  end

  assign ram_raddr = IdxW'(walk_q);

  tws_ram #(
    .Width (EntW),
    .Depth (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      walk_q     <= '0;
      lim_q      <= '0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
      power_q    <= 1'b0;
      chg_q      <= '0;
    end else begin
      rd_valid_q <= issue;
      if (issue) begin
        walk_q   <= walk_q + CntW'(1);
        rd_idx_q <= ram_raddr;
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (accept_in) begin
        walk_q <= '0;
        lim_q  <= lim_new;
        chg_q  <= '0;
      end else if (do_switch) begin
        power_q <= dec.sw_on;
        if (chg_q != CNT_MAX) begin
          chg_q <= chg_q + CntW'(1);
        end
      end
    end
  end

  // tick time, held for the whole walk
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      now_q.stamp   <= in_data_i.now_stamp;
      now_q.tod     <= in_data_i.now_tod;
      now_q.weekday <= in_data_i.now_weekday;
    end
  end

  // result register, refilled as soon as the previous result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_PUSH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PUSH && out_free) begin
      out_q.power_on     <= power_q;
      out_q.change_count <= chg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // no table read may still be in flight outside the walk
  a_no_read_outside_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WALK) |-> !rd_valid_q)
    else $error("table read pending outside walk");

  // every walk write-back belongs to an entry just read
  a_writeback_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == ST_WALK) |-> rd_valid_q)
    else $error("table write during walk without read data");

  // a tick never counts more changes than entries it has read
  a_changes_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chg_q <= walk_q)
    else $error("change count exceeds entries walked");

  // the walk never reads past its limit
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (walk_q <= lim_q))
    else $error("walk index beyond limit");
`endif

endmodule

[rtl/core/tws_ram.sv]
// tws_ram: generic single write port, single read port ram with registered read
// no dependencies
module tws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tws_eval.sv]
// tws_eval: window match and switch decision for one schedule entry
// depends on tws_pkg
module tws_eval (
  input  logic [1:0]         mode_i,
  input  tws_pkg::now_t      now_i,
  input  tws_pkg::entry_t    entry_i,
  input  logic               power_i,
  output tws_pkg::decision_t dec_o
);
  import tws_pkg::*;

  logic in_stamp;
  logic in_tod;
  logic in_win;
  logic day_ok;

  // inclusive bounds, end before start wraps around
  always_comb begin
    if (entry_i.end_stamp < entry_i.start_stamp) begin
      in_stamp = (now_i.stamp <= entry_i.end_stamp) || (now_i.stamp >= entry_i.start_stamp);
    end else begin
      in_stamp = (now_i.stamp >= entry_i.start_stamp) && (now_i.stamp <= entry_i.end_stamp);
    end
    if (entry_i.end_tod < entry_i.start_tod) begin
      in_tod = (now_i.tod <= entry_i.end_tod) || (now_i.tod >= entry_i.start_tod);
    end else begin
      in_tod = (now_i.tod >= entry_i.start_tod) && (now_i.tod <= entry_i.end_tod);
    end
  end

  assign in_win = (mode_i == MODE_STAMP) ? in_stamp : in_tod;
  // weekday only gates switching on
  assign day_ok = (mode_i != MODE_WEEKLY) || (entry_i.weekday == now_i.weekday);

  assign dec_o.sw_on  = !power_i && !entry_i.active && day_ok && in_win;
  assign dec_o.sw_off = power_i && entry_i.active && !in_win;

endmodule
